// ===== hdl/mcra_pkg.sv =====
// Shared types, constants and register indexes for the relative controller accumulator.
package mcra_pkg;

    localparam int NUM_CHANNELS_DEF = 128;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [3:0]  CC_STATUS   = 4'hB;
    localparam logic [19:0] VMAX_Q16    = 20'd655360;
    localparam logic [26:0] HALF_STEP   = 27'd327680;
    localparam logic [7:0]  STEP_SCALE  = 8'd250;
    localparam logic [6:0]  VOLT_MUL    = 7'd127;
    localparam logic [12:0] RECIP_TEN   = 13'd6554;
    localparam logic [6:0]  CC_MAX      = 7'd127;
    localparam logic [6:0]  CC_MIN      = 7'd0;

    localparam logic [16:0] GAIN_RESET  = 17'd65536;
    localparam logic [19:0] DELAY_RESET = 20'd5000;

    // Configuration register indexes.
    localparam logic REG_GAIN  = 1'b0;
    localparam logic REG_DELAY = 1'b1;

    // One classified input transaction as held in the queue.
    typedef struct packed {
        logic        is_cc_msg;
        logic        is_service;
        logic        in_range;
        logic [6:0]  channel;
        logic [6:0]  cc;
        logic [31:0] frame;
    } q_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DECIDE,
        ST_DIV,
        ST_MOVE,
        ST_CONV,
        ST_CODE,
        ST_FIN
    } state_t;

endpackage

// ===== hdl/mcra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcra_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/mcra_front.sv =====
// Input side: accepts transactions, classifies them and queues them for the back end.
module mcra_front
    import mcra_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [3:0]  status_nibble,
    input  logic [6:0]  channel,
    input  logic [6:0]  cc_in,
    input  logic [31:0] frame_now,
    output logic        head_valid,
    output q_item_t     head,
    input  logic        pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [7:0] NUM_CH = 8'(NUM_CHANNELS);

    q_item_t            queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    q_item_t            item;
    logic               push;
    logic               do_pop;

    // Classify the incoming transaction.
    always_comb
    begin
        item.is_cc_msg  = !kind && (status_nibble == CC_STATUS);
        item.is_service = kind;
        item.in_range   = ({1'b0, channel} < NUM_CH);
        item.channel    = channel;
        item.cc         = cc_in;
        item.frame      = frame_now;
    end

    assign in_stall   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign head       = queue[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue[wr_ptr_reg] <= item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/mcra_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mcra_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [24:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [24:0] quotient
);

    logic [31:0] rem_reg;
    logic [24:0] quo_reg;
    logic [31:0] div_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial    = {rem_reg, quo_reg[24]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    // Data path of the iteration.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
            quo_reg <= {quo_reg[23:0], fits};
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= 5'd24;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/mcra_back.sv =====
// Back end: sequencer that carries out messages and channel services.
module mcra_back
    import mcra_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [16:0] gain,
    input  logic [19:0] delay,
    input  logic        head_valid,
    input  q_item_t     head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_channel,
    output logic [19:0] voltage,
    output logic        send_back,
    output logic [6:0]  cc_out
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    state_t state_reg, state_next;

    // Per-channel flags kept in flip-flops.
    logic pend_v  [NUM_CHANNELS];
    logic prev_v  [NUM_CHANNELS];
    logic corr    [NUM_CHANNELS];
    logic touched [NUM_CHANNELS];

    logic [IDX_W-1:0] head_idx;
    logic [IDX_W-1:0] idx_reg;
    logic        pend_rd_reg;
    logic        prev_rd_reg;
    logic        corr_rd_reg;
    logic        touch_rd_reg;
    logic [6:0]  ch_reg,    ch_next;
    logic [31:0] frame_reg, frame_next;
    logic [19:0] v_reg,     v_next;
    logic [31:0] last_reg,  last_next;
    logic [6:0]  prev_reg,  prev_next;
    logic [6:0]  pend_reg,  pend_next;
    logic        pv_reg,    pv_next;
    logic        ppv_reg,   ppv_next;
    logic        corr_reg,  corr_next;
    logic [31:0] gap_reg,   gap_next;
    logic [10:0] num_reg,   num_next;
    logic        send_reg,  send_next;
    logic [6:0]  cc_reg,    cc_next;

    logic        out_valid_reg;
    logic [6:0]  out_ch_reg;
    logic [19:0] out_v_reg;
    logic        out_send_reg;
    logic [6:0]  out_cc_reg;
    logic        out_load;

    logic        pend_we;
    logic        state_we;
    logic [58:0] state_wdata;
    logic [6:0]  pend_rdata;
    logic [58:0] state_rdata;
    logic        msg_set;
    logic        move_done;
    logic        sync_done;

    logic        div_start;
    logic [24:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [24:0] div_q;

    logic        dir_up;
    logic        dir_dn;
    logic [25:0] up_sum;
    logic [26:0] conv_prod;
    logic [23:0] code_prod;
    logic [7:0]  code_raw;
    logic [6:0]  code_val;

    assign head_idx = head.channel[IDX_W-1:0];

    mcra_ram #(.WIDTH(7), .DEPTH(NUM_CHANNELS), .ADDR_W(IDX_W)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (head_idx),
        .wdata (head.cc),
        .raddr (head_idx),
        .rdata (pend_rdata)
    );

    mcra_ram #(.WIDTH(59), .DEPTH(NUM_CHANNELS), .ADDR_W(IDX_W)) u_state_ram (
        .clk   (clk),
        .we    (state_we),
        .waddr (idx_reg),
        .wdata (state_wdata),
        .raddr (head_idx),
        .rdata (state_rdata)
    );

    mcra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Direction of the move from the pending and previous values.
    always_comb
    begin
        dir_up = 1'b0;
        dir_dn = 1'b0;
        priority if (!ppv_reg || pend_reg > prev_reg)
        begin
            dir_up = 1'b1;
        end
        else if (pend_reg < prev_reg)
        begin
            dir_dn = 1'b1;
        end
        else if (pend_reg == CC_MAX)
        begin
            dir_up = 1'b1;
        end
        else if (pend_reg == CC_MIN)
        begin
            dir_dn = 1'b1;
        end
    end

    assign up_sum       = {6'd0, v_reg} + {1'b0, div_q};
    assign conv_prod    = 27'(v_reg * VOLT_MUL) + HALF_STEP;
    assign code_prod    = 24'(num_reg * RECIP_TEN);
    assign code_raw     = code_prod[23:16];
    assign code_val     = (code_raw > {1'b0, CC_MAX}) ? CC_MAX : code_raw[6:0];
    assign div_dividend = 25'(gain * STEP_SCALE);
    assign div_divisor  = (gap_reg == '0) ? 32'd1 : gap_reg;

    // Next state and sequencer outputs.
    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        frame_next  = frame_reg;
        v_next      = v_reg;
        last_next   = last_reg;
        prev_next   = prev_reg;
        pend_next   = pend_reg;
        pv_next     = pv_reg;
        ppv_next    = ppv_reg;
        corr_next   = corr_reg;
        gap_next    = gap_reg;
        num_next    = num_reg;
        send_next   = send_reg;
        cc_next     = cc_reg;
        pop         = 1'b0;
        pend_we     = 1'b0;
        msg_set     = 1'b0;
        state_we    = 1'b0;
        state_wdata = {prev_reg, v_reg, last_reg};
        move_done   = 1'b0;
        sync_done   = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (!head.is_service)
                    begin
                        if (head.is_cc_msg && head.in_range)
                        begin
                            pend_we = 1'b1;
                            msg_set = 1'b1;
                        end
                    end
                    else
                    begin
                        ch_next    = head.channel;
                        frame_next = head.frame;
                        send_next  = 1'b0;
                        cc_next    = '0;
                        v_next     = '0;
                        state_next = head.in_range ? ST_LOAD : ST_FIN;
                    end
                end
            end
            ST_LOAD:
            begin
                v_next     = touch_rd_reg ? state_rdata[51:32] : '0;
                last_next  = touch_rd_reg ? state_rdata[31:0] : '0;
                gap_next   = frame_reg - (touch_rd_reg ? state_rdata[31:0] : 32'd0);
                prev_next  = state_rdata[58:52];
                pend_next  = pend_rdata;
                pv_next    = pend_rd_reg;
                ppv_next   = prev_rd_reg;
                corr_next  = corr_rd_reg;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                priority if (pv_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (!corr_reg && gap_reg > {12'd0, delay})
                begin
                    state_next = ST_CONV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                priority if (dir_up)
                begin
                    v_next = (up_sum > {6'd0, VMAX_Q16}) ? VMAX_Q16 : up_sum[19:0];
                end
                else if (dir_dn)
                begin
                    v_next = (div_q >= {5'd0, v_reg}) ? 20'd0 : 20'(v_reg - div_q[19:0]);
                end
                else
                begin
                    v_next = v_reg;
                end
                state_we    = 1'b1;
                state_wdata = {pend_reg, v_next, frame_reg};
                move_done   = 1'b1;
                state_next  = ST_FIN;
            end
            ST_CONV:
            begin
                num_next   = conv_prod[26:16];
                state_next = ST_CODE;
            end
            ST_CODE:
            begin
                if (!ppv_reg || code_val != prev_reg)
                begin
                    send_next   = 1'b1;
                    cc_next     = code_val;
                    state_we    = 1'b1;
                    state_wdata = {code_val, v_reg, last_reg};
                    sync_done   = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of the serviced channel; the flags are read with the RAMs.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            idx_reg      <= head_idx;
            pend_rd_reg  <= pend_v[head_idx];
            prev_rd_reg  <= prev_v[head_idx];
            corr_rd_reg  <= corr[head_idx];
            touch_rd_reg <= touched[head_idx];
        end
        ch_reg    <= ch_next;
        frame_reg <= frame_next;
        v_reg     <= v_next;
        last_reg  <= last_next;
        prev_reg  <= prev_next;
        pend_reg  <= pend_next;
        pv_reg    <= pv_next;
        ppv_reg   <= ppv_next;
        corr_reg  <= corr_next;
        gap_reg   <= gap_next;
        num_reg   <= num_next;
        send_reg  <= send_next;
        cc_reg    <= cc_next;
    end

    // Per-channel flags: pending, previous valid, corrected and written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pend_v[i]  <= 1'b0;
                prev_v[i]  <= 1'b0;
                corr[i]    <= 1'b1;
                touched[i] <= 1'b0;
            end
        end
        else
        begin
            if (msg_set)
            begin
                pend_v[head_idx] <= 1'b1;
            end
            if (move_done)
            begin
                pend_v[idx_reg]  <= 1'b0;
                prev_v[idx_reg]  <= 1'b1;
                corr[idx_reg]    <= 1'b0;
                touched[idx_reg] <= 1'b1;
            end
            if (sync_done)
            begin
                prev_v[idx_reg]  <= 1'b1;
                corr[idx_reg]    <= 1'b1;
                touched[idx_reg] <= 1'b1;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch_reg   <= ch_reg;
            out_v_reg    <= v_reg;
            out_send_reg <= send_reg;
            out_cc_reg   <= cc_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign voltage     = out_v_reg;
    assign send_back   = out_send_reg;
    assign cc_out      = out_cc_reg;

endmodule

// ===== hdl/midi_cc_relative_accumulator_unit.sv =====
// Top level of the relative controller accumulator: configuration, queue and sequencer.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------------
//  input    | in_valid/in_stall  | kind, status_nibble, channel, cc_in, frame_now
//  output   | out_valid/out_stall| out_channel, voltage, send_back, cc_out
//  config   | cfg_we             | cfg_index, cfg_data
//
// A message transaction is taken in the idle state; an in-range service runs load, decide,
// then the 25-step restoring divider and move, or convert and code, or neither, then finish.
// The queue in front holds QUEUE_DEPTH transactions (four by default), so input accepts while the sequencer works.
// Reset sets all per-channel flags at once (corrected set, the rest clear); there is no clearing pass.
// A held result in the output register stalls only the sequencer's final step.
module midi_cc_relative_accumulator_unit
    import mcra_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [3:0]  status_nibble,
    input  logic [6:0]  channel,
    input  logic [6:0]  cc_in,
    input  logic [31:0] frame_now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_channel,
    output logic [19:0] voltage,
    output logic        send_back,
    output logic [6:0]  cc_out
);

    logic [16:0] gain_reg;
    logic [19:0] delay_reg;
    logic        head_valid;
    q_item_t     head;
    logic        pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            delay_reg <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_data[16:0];
                REG_DELAY: delay_reg <= cfg_data;
                default:   delay_reg <= delay_reg;
            endcase
        end
    end

    mcra_front #(.NUM_CHANNELS(NUM_CHANNELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .status_nibble (status_nibble),
        .channel       (channel),
        .cc_in         (cc_in),
        .frame_now     (frame_now),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop)
    );

    mcra_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .gain        (gain_reg),
        .delay       (delay_reg),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .voltage     (voltage),
        .send_back   (send_back),
        .cc_out      (cc_out)
    );

endmodule
